### design/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the ring refill scheduler
// Holds the microcode word layout, opcodes, jump and wait selects, register
// indexes, status codes and the datapath flag group.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

	localparam int unsigned RING_INDEX_BITS = 24;
	localparam int unsigned LEN_BITS        = 13;
	localparam int unsigned TOTAL_BITS      = 17;
	localparam int unsigned BUDGET_BITS     = 5;
	localparam int unsigned PC_BITS         = 3;

	localparam logic [LEN_BITS-1:0]    STEP_BYTES = 13'd4096;
	localparam logic [BUDGET_BITS-1:0] MAX_BUDGET = 5'd16;
	localparam logic [4:0]             RING_LG_MAX = 5'd24;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	localparam logic [2:0] REG_STREAM_OFFSET = 3'd0;
	localparam logic [2:0] REG_STREAM_SIZE   = 3'd1;
	localparam logic [2:0] REG_RING_LG       = 3'd2;
	localparam logic [2:0] REG_LOOP_ENABLE   = 3'd3;
	localparam logic [2:0] REG_CARD_BYTES    = 3'd4;

	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_USED    = 3'd1;
	localparam logic [2:0] OP_ROOM    = 3'd2;
	localparam logic [2:0] OP_CLIP    = 3'd3;
	localparam logic [2:0] OP_COMMIT  = 3'd4;
	localparam logic [2:0] OP_HOLD    = 3'd5;
	localparam logic [2:0] OP_FINAL   = 3'd6;
	localparam logic [2:0] OP_RESTART = 3'd7;

	localparam logic [1:0] W_NONE = 2'd0;
	localparam logic [1:0] W_IN   = 2'd1;
	localparam logic [1:0] W_OUT  = 2'd2;
	localparam logic [1:0] W_HOLD = 2'd3;

	localparam logic [2:0] J_NONE   = 3'd0;
	localparam logic [2:0] J_ALWAYS = 3'd1;
	localparam logic [2:0] J_MODE0  = 3'd2;
	localparam logic [2:0] J_STOP   = 3'd3;
	localparam logic [2:0] J_FULL   = 3'd4;
	localparam logic [2:0] J_BAD    = 3'd5;

	localparam logic [PC_BITS-1:0] PC_IDLE    = 3'd0;
	localparam logic [PC_BITS-1:0] PC_LOOP    = 3'd1;
	localparam logic [PC_BITS-1:0] PC_ROOM    = 3'd2;
	localparam logic [PC_BITS-1:0] PC_CLIP    = 3'd3;
	localparam logic [PC_BITS-1:0] PC_COMMIT  = 3'd4;
	localparam logic [PC_BITS-1:0] PC_HOLD    = 3'd5;
	localparam logic [PC_BITS-1:0] PC_END     = 3'd6;
	localparam logic [PC_BITS-1:0] PC_RESTART = 3'd7;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         wait_sel;
		logic [2:0]         jmp_sel;
		logic [PC_BITS-1:0] jmp_tgt;
	} ucode_word_t;

	typedef struct packed {
		logic [2:0] op;
		logic       go;
	} dp_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic mode0;
		logic stop;
		logic full;
		logic bad;
		logic out_free;
		logic hold_free;
	} dp_flags_t;

endpackage

`default_nettype wire

### design/ring_refill_scheduler.sv
// ----------------------------------------------------------------------------
// ring_refill_scheduler: plans copies that refill a ring buffer from a card
// A request on s_axis is a restart (tuser 0) or a refill step (tuser 1) with
// the play position and a budget in tdata. Each request yields one or more
// copy commands on m_axis; tlast marks the final command of the request.
// After acceptance, a restart loads its zero-length command into the output
// register once that is free. A step runs a five-step microcode loop per copy,
// at most as many times as its budget, which is clamped at 16. A step that
// makes no copy yields one zero-length command with the current status.
// Configuration on cfg_wen/cfg_addr/cfg_wdata is written by the user only
// while idle; the block does not enforce this. Reset clears positions and
// sets status to done; a restart request must come before any copy is planned.
// When m_axis stalls, one command waits in the output register and one more
// in a pending register; the sequencer then holds until space frees up.
// s_axis_tready is high only while the sequencer waits for a new request.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_refill_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // play position, budget, zero fill
	input  wire logic        s_axis_tuser,  // mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,  // card_offset, ring_index, copy_length,
	                                        // added_total, stream_status
	output logic             m_axis_tlast   // last
);

	rrs_pkg::dp_ctrl_t  ctrl;
	rrs_pkg::dp_flags_t flags;
	logic [31:0]        out_offset;
	logic [23:0]        out_index;
	logic [12:0]        out_length;
	logic [16:0]        out_total;
	logic [1:0]         out_status;

	rrs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	rrs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mode    (s_axis_tuser),
		.in_play    (s_axis_tdata[31:0]),
		.in_budget  (s_axis_tdata[36:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_offset (out_offset),
		.out_index  (out_index),
		.out_length (out_length),
		.out_last   (m_axis_tlast),
		.out_total  (out_total),
		.out_status (out_status),
		.ctrl       (ctrl),
		.flags      (flags)
	);

	assign m_axis_tdata = {out_status, out_total, out_length, out_index, out_offset};

endmodule

`default_nettype wire

### design/rrs_ucode_rom.sv
// ----------------------------------------------------------------------------
// rrs_ucode_rom: microcode program of the refill scheduler
// One control word per step: datapath operation, wait condition and jump.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_ucode_rom (
	input  wire logic [rrs_pkg::PC_BITS-1:0] pc,
	output rrs_pkg::ucode_word_t             word
);

	always_comb begin
		case (pc)
			rrs_pkg::PC_IDLE: word = '{rrs_pkg::OP_LOAD, rrs_pkg::W_IN,
				rrs_pkg::J_MODE0, rrs_pkg::PC_RESTART};
			rrs_pkg::PC_LOOP: word = '{rrs_pkg::OP_USED, rrs_pkg::W_NONE,
				rrs_pkg::J_STOP, rrs_pkg::PC_END};
			rrs_pkg::PC_ROOM: word = '{rrs_pkg::OP_ROOM, rrs_pkg::W_NONE,
				rrs_pkg::J_FULL, rrs_pkg::PC_END};
			rrs_pkg::PC_CLIP: word = '{rrs_pkg::OP_CLIP, rrs_pkg::W_NONE,
				rrs_pkg::J_NONE, rrs_pkg::PC_IDLE};
			rrs_pkg::PC_COMMIT: word = '{rrs_pkg::OP_COMMIT, rrs_pkg::W_NONE,
				rrs_pkg::J_BAD, rrs_pkg::PC_END};
			rrs_pkg::PC_HOLD: word = '{rrs_pkg::OP_HOLD, rrs_pkg::W_HOLD,
				rrs_pkg::J_ALWAYS, rrs_pkg::PC_LOOP};
			rrs_pkg::PC_END: word = '{rrs_pkg::OP_FINAL, rrs_pkg::W_OUT,
				rrs_pkg::J_ALWAYS, rrs_pkg::PC_IDLE};
			rrs_pkg::PC_RESTART: word = '{rrs_pkg::OP_RESTART, rrs_pkg::W_OUT,
				rrs_pkg::J_ALWAYS, rrs_pkg::PC_IDLE};
			default: word = '{rrs_pkg::OP_LOAD, rrs_pkg::W_IN,
				rrs_pkg::J_MODE0, rrs_pkg::PC_RESTART};
		endcase
	end

endmodule

`default_nettype wire

### design/rrs_sequencer.sv
// ----------------------------------------------------------------------------
// rrs_sequencer: step counter and jump logic of the refill scheduler
// Reads the control word of the current step, holds the step while its wait
// condition is unmet, and picks the next step from the jump select.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_sequencer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rrs_pkg::dp_flags_t flags,
	output rrs_pkg::dp_ctrl_t       ctrl
);

	logic [rrs_pkg::PC_BITS-1:0] pc_q;
	rrs_pkg::ucode_word_t        word;
	logic                        stalled;
	logic                        jump;

	rrs_ucode_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	always_comb begin
		case (word.wait_sel)
			rrs_pkg::W_NONE: stalled = 1'b0;
			rrs_pkg::W_IN:   stalled = !flags.in_valid;
			rrs_pkg::W_OUT:  stalled = !flags.out_free;
			rrs_pkg::W_HOLD: stalled = !flags.hold_free;
			default:         stalled = 1'b0;
		endcase
	end

	always_comb begin
		case (word.jmp_sel)
			rrs_pkg::J_NONE:   jump = 1'b0;
			rrs_pkg::J_ALWAYS: jump = 1'b1;
			rrs_pkg::J_MODE0:  jump = flags.mode0;
			rrs_pkg::J_STOP:   jump = flags.stop;
			rrs_pkg::J_FULL:   jump = flags.full;
			rrs_pkg::J_BAD:    jump = flags.bad;
			default:           jump = 1'b0;
		endcase
	end

	assign ctrl = '{op: word.op, go: !stalled};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rrs_pkg::PC_IDLE;
		end else if (!stalled) begin
			if (jump) begin
				pc_q <= word.jmp_tgt;
			end else begin
				pc_q <= pc_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

### design/rrs_datapath.sv
// ----------------------------------------------------------------------------
// rrs_datapath: registers and arithmetic of the refill scheduler
// Holds configuration, stream state, the working registers of one copy, a
// pending result and the output register; microcode ops drive all but config.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [2:0]        cfg_addr,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_mode,
	input  wire logic [31:0]       in_play,
	input  wire logic [4:0]        in_budget,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            out_offset,
	output logic [23:0]            out_index,
	output logic [12:0]            out_length,
	output logic                   out_last,
	output logic [16:0]            out_total,
	output logic [1:0]             out_status,
	input  wire rrs_pkg::dp_ctrl_t ctrl,
	output rrs_pkg::dp_flags_t     flags
);

	logic [31:0] stream_offset_q;
	logic [31:0] stream_size_q;
	logic [4:0]  ring_lg_q;
	logic        loop_enable_q;
	logic [31:0] card_bytes_q;

	logic [31:0] fill_q;
	logic [31:0] asset_q;
	logic [1:0]  status_q;

	logic [31:0] play_q;
	logic [4:0]  budget_q;
	logic [31:0] used_q;
	logic [31:0] asset_left_q;
	logic [12:0] n_q;
	logic [23:0] idx_q;
	logic [31:0] src_q;
	logic [16:0] added_q;

	logic        hold_v_q;
	logic [31:0] hold_offset_q;
	logic [23:0] hold_index_q;
	logic [12:0] hold_length_q;
	logic [16:0] hold_total_q;
	logic [1:0]  hold_status_q;

	logic        out_valid_q;
	logic        out_free;
	logic        out_load;
	logic        go;
	logic        in_acc;

	logic [4:0]  ring_lg;
	logic [24:0] ring_bytes;
	logic [23:0] ring_wrap;
	logic [31:0] room;
	logic [23:0] idx_new;
	logic [12:0] n_asset;
	logic [24:0] ring_tail;
	logic [31:0] card_left;
	logic        bad;
	logic        at_end;
	logic [1:0]  status_new;

	assign go       = ctrl.go;
	assign in_ready = (ctrl.op == rrs_pkg::OP_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = go && (((ctrl.op == rrs_pkg::OP_HOLD) && hold_v_q)
		|| (ctrl.op == rrs_pkg::OP_FINAL) || (ctrl.op == rrs_pkg::OP_RESTART));

	assign ring_lg    = (ring_lg_q > rrs_pkg::RING_LG_MAX) ? rrs_pkg::RING_LG_MAX : ring_lg_q;
	assign ring_bytes = 25'd1 << ring_lg;
	assign ring_wrap  = ring_bytes[23:0] - 24'd1;
	assign room       = {7'd0, ring_bytes} - used_q;
	assign idx_new    = fill_q[23:0] & ring_wrap;
	assign n_asset    = (asset_left_q < {19'd0, n_q}) ? asset_left_q[12:0] : n_q;
	assign ring_tail  = ring_bytes - {1'b0, idx_new};
	assign card_left  = card_bytes_q - src_q;
	assign bad        = (card_bytes_q != 32'd0)
		&& ((src_q > card_bytes_q) || ({19'd0, n_q} > card_left));
	assign at_end     = (asset_q >= stream_size_q);
	assign status_new = (at_end && !loop_enable_q) ? rrs_pkg::ST_DONE : status_q;

	assign flags = '{
		in_valid:  in_valid,
		mode0:     !in_mode,
		stop:      (budget_q == 5'd0) || (status_q != rrs_pkg::ST_RUN),
		full:      (used_q >= {7'd0, ring_bytes}),
		bad:       bad,
		out_free:  out_free,
		hold_free: !hold_v_q || out_free
	};

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_offset_q <= 32'd0;
			stream_size_q   <= 32'd0;
			ring_lg_q       <= 5'd12;
			loop_enable_q   <= 1'b0;
			card_bytes_q    <= 32'd0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				rrs_pkg::REG_STREAM_OFFSET: stream_offset_q <= cfg_wdata;
				rrs_pkg::REG_STREAM_SIZE:   stream_size_q   <= cfg_wdata;
				rrs_pkg::REG_RING_LG:       ring_lg_q       <= cfg_wdata[4:0];
				rrs_pkg::REG_LOOP_ENABLE:   loop_enable_q   <= cfg_wdata[0];
				rrs_pkg::REG_CARD_BYTES:    card_bytes_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 32'd0;
			asset_q     <= 32'd0;
			status_q    <= rrs_pkg::ST_DONE;
			hold_v_q    <= 1'b0;
			budget_q    <= 5'd0;
			added_q     <= 17'd0;
		end else begin
			if (go) begin
				case (ctrl.op)
					rrs_pkg::OP_LOAD: begin
						if (in_acc) begin
							budget_q <= (in_budget > rrs_pkg::MAX_BUDGET)
								? rrs_pkg::MAX_BUDGET : in_budget;
							added_q  <= 17'd0;
						end
					end
					rrs_pkg::OP_USED: begin
						budget_q <= budget_q - 5'd1;
					end
					rrs_pkg::OP_COMMIT: begin
						if (bad) begin
							status_q <= rrs_pkg::ST_ERROR;
						end else begin
							fill_q  <= fill_q + {19'd0, n_q};
							asset_q <= asset_q + {19'd0, n_q};
							added_q <= added_q + {4'd0, n_q};
						end
					end
					rrs_pkg::OP_HOLD: begin
						if (at_end && loop_enable_q) begin
							asset_q <= 32'd0;
						end
						status_q <= status_new;
						hold_v_q <= 1'b1;
					end
					rrs_pkg::OP_FINAL: begin
						hold_v_q    <= 1'b0;
					end
					rrs_pkg::OP_RESTART: begin
						fill_q      <= 32'd0;
						asset_q     <= 32'd0;
						status_q    <= (stream_size_q != 32'd0)
							? rrs_pkg::ST_RUN : rrs_pkg::ST_ERROR;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (ctrl.op)
				rrs_pkg::OP_LOAD: begin
					if (in_acc) begin
						play_q <= in_play;
					end
				end
				rrs_pkg::OP_USED: begin
					used_q <= fill_q - play_q;
				end
				rrs_pkg::OP_ROOM: begin
					n_q <= (room < {19'd0, rrs_pkg::STEP_BYTES})
						? room[12:0] : rrs_pkg::STEP_BYTES;
					asset_left_q <= stream_size_q - asset_q;
				end
				rrs_pkg::OP_CLIP: begin
					n_q   <= (ring_tail < {12'd0, n_asset}) ? ring_tail[12:0] : n_asset;
					idx_q <= idx_new;
					src_q <= stream_offset_q + asset_q;
				end
				rrs_pkg::OP_HOLD: begin
					if (hold_v_q) begin
						out_offset <= hold_offset_q;
						out_index  <= hold_index_q;
						out_length <= hold_length_q;
						out_last   <= 1'b0;
						out_total  <= hold_total_q;
						out_status <= hold_status_q;
					end
					hold_offset_q <= src_q;
					hold_index_q  <= idx_q;
					hold_length_q <= n_q;
					hold_total_q  <= added_q;
					hold_status_q <= status_new;
				end
				rrs_pkg::OP_FINAL: begin
					out_last   <= 1'b1;
					out_status <= status_q;
					if (hold_v_q) begin
						out_offset <= hold_offset_q;
						out_index  <= hold_index_q;
						out_length <= hold_length_q;
						out_total  <= hold_total_q;
					end else begin
						out_offset <= 32'd0;
						out_index  <= 24'd0;
						out_length <= 13'd0;
						out_total  <= 17'd0;
					end
				end
				rrs_pkg::OP_RESTART: begin
					out_offset <= 32'd0;
					out_index  <= 24'd0;
					out_length <= 13'd0;
					out_last   <= 1'b1;
					out_total  <= 17'd0;
					out_status <= (stream_size_q != 32'd0)
						? rrs_pkg::ST_RUN : rrs_pkg::ST_ERROR;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/sv/ring_refill_scheduler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_refill_scheduler_test: self-checking bench for the ring refill scheduler
// A short table of restart and step requests, with register writes between
// them, covers empty and shrunk assets, full and overrun rings, the ring end,
// looping, the card bounds check and budget and ring size clamping. Random
// phases follow, each with new register settings and mostly well-formed play
// positions. Each command is checked field by field against an in-bench model
// of the fill, asset and status state, or a typed row's zero-length command.
// ----------------------------------------------------------------------------

module ring_refill_scheduler_test;

	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_STEP    = 1'b1;

	typedef struct packed {
		logic [31:0]                         card_offset;
		logic [rrs_pkg::RING_INDEX_BITS-1:0] ring_index;
		logic [rrs_pkg::LEN_BITS-1:0]        copy_length;
		logic                                last;
		logic [rrs_pkg::TOTAL_BITS-1:0]      added_total;
		logic [1:0]                          stream_status;
	} copy_cmd_t;

	typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  sel;
		logic [31:0] value;
		logic [4:0]  budget;
		bit          typed;
		logic [1:0]  st;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tlast;

	ring_refill_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Register copies and stream state of the scheduling model.
	logic [31:0] offset_reg;
	logic [31:0] size_reg;
	logic [4:0]  ring_lg_reg;
	logic        loop_reg;
	logic [31:0] card_reg;
	logic [31:0] fill_mark;
	logic [31:0] asset_pos;
	logic [1:0]  stream_st;

	copy_cmd_t step_plan[$];
	copy_cmd_t pending_cmds[$];
	copy_cmd_t seen_cmd;
	copy_cmd_t want_cmd;
	stim_row_t dir_rows[$];

	int  err_count;
	int  cmd_count;
	int  request_count;
	int  restart_count;
	int  copy_count;
	int  settings_count;
	int  rand_items;
	int  steps_left;
	int  hold_left;
	bit  hold_req;
	bit  no_idle;

	longint      bytes_planned;
	logic [63:0] ring_now;
	logic [31:0] play_pick;
	logic [31:0] off_pick;
	logic [31:0] size_pick;
	logic [4:0]  budget_pick;
	logic        mode_pick;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("mismatch on command %0d, %s: expected %0h, got %0h",
			cmd_count, what, want, got);
		err_count++;
	endtask

	// Works out the copy commands of one request and advances the state.
	task automatic plan_request(input logic mode, input logic [31:0] play,
		input logic [4:0] budget);
		logic [4:0]  lg;
		logic [63:0] ring;
		logic [63:0] used;
		logic [63:0] n;
		logic [63:0] room;
		logic [31:0] mask;
		logic [31:0] src;
		logic [31:0] idx;
		logic [16:0] added;
		int          left;
		int          k;
		step_plan.delete();
		if (mode == MODE_RESTART) begin
			fill_mark = 32'd0;
			asset_pos = 32'd0;
			stream_st = (size_reg != 32'd0) ? rrs_pkg::ST_RUN : rrs_pkg::ST_ERROR;
			step_plan.push_back('{32'd0, 24'd0, 13'd0, 1'b1, 17'd0, stream_st});
		end else begin
			lg = (ring_lg_reg > rrs_pkg::RING_LG_MAX) ? rrs_pkg::RING_LG_MAX : ring_lg_reg;
			ring = 64'd1 << lg;
			mask = 32'(ring - 64'd1);
			left = (budget > rrs_pkg::MAX_BUDGET) ? int'(rrs_pkg::MAX_BUDGET) : int'(budget);
			added = 17'd0;
			while (left > 0 && stream_st == rrs_pkg::ST_RUN) begin
				left--;
				used = {32'd0, fill_mark - play};
				if (used > ring)
					break;
				n = {51'd0, rrs_pkg::STEP_BYTES};
				if (n > ring - used)
					n = ring - used;
				if (n == 64'd0)
					break;
				room = {32'd0, size_reg - asset_pos};
				if (n > room)
					n = room;
				idx = fill_mark & mask;
				if (n > ring - {32'd0, idx})
					n = ring - {32'd0, idx};
				src = offset_reg + asset_pos;
				if (card_reg != 32'd0 && (src > card_reg || n > {32'd0, card_reg - src})) begin
					stream_st = rrs_pkg::ST_ERROR;
					break;
				end
				fill_mark += n[31:0];
				asset_pos += n[31:0];
				added += n[16:0];
				if (asset_pos >= size_reg) begin
					if (loop_reg)
						asset_pos = 32'd0;
					else
						stream_st = rrs_pkg::ST_DONE;
				end
				step_plan.push_back('{src, idx[23:0], n[12:0], 1'b0, added, stream_st});
			end
			if (step_plan.size() == 0) begin
				step_plan.push_back('{32'd0, 24'd0, 13'd0, 1'b1, 17'd0, stream_st});
			end else begin
				k = step_plan.size() - 1;
				step_plan[k].last = 1'b1;
				step_plan[k].stream_status = stream_st;
			end
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || !s_axis_tready);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			rrs_pkg::REG_STREAM_OFFSET: offset_reg = value;
			rrs_pkg::REG_STREAM_SIZE:   size_reg = value;
			rrs_pkg::REG_RING_LG:       ring_lg_reg = value[4:0];
			rrs_pkg::REG_LOOP_ENABLE:   loop_reg = value[0];
			rrs_pkg::REG_CARD_BYTES:    card_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_request(input logic mode, input logic [31:0] play,
		input logic [4:0] budget, input bit typed, input logic [1:0] typed_st);
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 14) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, budget, play};
		s_axis_tuser <= mode;
		do
			@(posedge clk);
		while (!s_axis_tready);
		plan_request(mode, play, budget);
		request_count++;
		if (mode == MODE_RESTART)
			restart_count++;
		if (typed) begin
			pending_cmds.push_back('{32'd0, 24'd0, 13'd0, 1'b1, 17'd0, typed_st});
		end else begin
			foreach (step_plan[i])
				pending_cmds.push_back(step_plan[i]);
		end
	endtask

	// Receiver: random stalls, a quiet window, and one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_cmd.card_offset = m_axis_tdata[31:0];
			seen_cmd.ring_index = m_axis_tdata[55:32];
			seen_cmd.copy_length = m_axis_tdata[68:56];
			seen_cmd.added_total = m_axis_tdata[85:69];
			seen_cmd.stream_status = m_axis_tdata[87:86];
			seen_cmd.last = m_axis_tlast;
			if (pending_cmds.size() == 0) begin
				report_mismatch("command with none expected", 32'd0,
					seen_cmd.card_offset);
			end else begin
				want_cmd = pending_cmds.pop_front();
				if (seen_cmd.card_offset !== want_cmd.card_offset)
					report_mismatch("card_offset", want_cmd.card_offset,
						seen_cmd.card_offset);
				if (seen_cmd.ring_index !== want_cmd.ring_index)
					report_mismatch("ring_index", 32'(want_cmd.ring_index),
						32'(seen_cmd.ring_index));
				if (seen_cmd.copy_length !== want_cmd.copy_length)
					report_mismatch("copy_length", 32'(want_cmd.copy_length),
						32'(seen_cmd.copy_length));
				if (seen_cmd.last !== want_cmd.last)
					report_mismatch("last", 32'(want_cmd.last), 32'(seen_cmd.last));
				if (seen_cmd.added_total !== want_cmd.added_total)
					report_mismatch("added_total", 32'(want_cmd.added_total),
						32'(seen_cmd.added_total));
				if (seen_cmd.stream_status !== want_cmd.stream_status)
					report_mismatch("stream_status", 32'(want_cmd.stream_status),
						32'(seen_cmd.stream_status));
				if (seen_cmd.copy_length != 13'd0)
					copy_count++;
				bytes_planned += seen_cmd.copy_length;
			end
			cmd_count++;
		end
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_addr = 3'd0;
		cfg_wdata = 32'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 40'd0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		offset_reg = 32'd0;
		size_reg = 32'd0;
		ring_lg_reg = 5'd12;
		loop_reg = 1'b0;
		card_reg = 32'd0;
		fill_mark = 32'd0;
		asset_pos = 32'd0;
		stream_st = rrs_pkg::ST_DONE;
		err_count = 0;
		cmd_count = 0;
		request_count = 0;
		restart_count = 0;
		copy_count = 0;
		settings_count = 0;
		rand_items = 0;
		hold_left = 0;
		hold_req = 1'b0;
		no_idle = 1'b0;
		bytes_planned = 0;

		dir_rows = '{
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd16, 1'b1, rrs_pkg::ST_DONE},
			'{ROW_REQ, MODE_RESTART, 32'hFFFF_FFFF, 5'd31, 1'b1, rrs_pkg::ST_ERROR},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd5, 1'b1, rrs_pkg::ST_ERROR},
			'{ROW_CFG, rrs_pkg::REG_STREAM_OFFSET, 32'hFFFF_F000, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_STREAM_SIZE, 32'd20000, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_CARD_BYTES, 32'd0, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_LOOP_ENABLE, 32'd0, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_RING_LG, 32'd12, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_RESTART, 32'd0, 5'd0, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd3, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd0, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd4096, 5'd31, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd16, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd8192, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd12288, 5'd1, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd16384, 5'd2, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd20000, 5'd4, 1'b1, rrs_pkg::ST_DONE},
			'{ROW_CFG, rrs_pkg::REG_RING_LG, 32'd4, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_STREAM_SIZE, 32'd40, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_STREAM_OFFSET, 32'd0, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_LOOP_ENABLE, 32'd1, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_RESTART, 32'd0, 5'd0, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd16, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd32, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd40, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_RING_LG, 32'd31, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_STREAM_SIZE, 32'h1000_0000, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_CARD_BYTES, 32'd50000, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_LOOP_ENABLE, 32'd0, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_RESTART, 32'd0, 5'd0, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd16, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_CARD_BYTES, 32'd0, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_RING_LG, 32'd24, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_STREAM_OFFSET, 32'hFFFF_FFFF, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_RESTART, 32'd0, 5'd0, 1'b1, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd2, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_CFG, rrs_pkg::REG_STREAM_SIZE, 32'd100, 5'd0, 1'b0, rrs_pkg::ST_RUN},
			'{ROW_REQ, MODE_STEP, 32'd0, 5'd16, 1'b0, rrs_pkg::ST_RUN}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].sel, dir_rows[i].value);
			else
				send_request(dir_rows[i].sel[0], dir_rows[i].value, dir_rows[i].budget,
					dir_rows[i].typed, dir_rows[i].st);
		end

		while (rand_items < 230) begin
			case ($urandom_range(0, 3))
				0: off_pick = 32'd0;
				1: off_pick = 32'hFFFF_FFFF;
				default: off_pick = $urandom;
			endcase
			case ($urandom_range(0, 19))
				0: size_pick = 32'd0;
				1: size_pick = 32'hFFFF_FFFF;
				2, 3, 4, 5: size_pick = $urandom_range(1, 64);
				default: size_pick = $urandom_range(1, 200000);
			endcase
			write_reg(rrs_pkg::REG_STREAM_OFFSET, off_pick);
			write_reg(rrs_pkg::REG_STREAM_SIZE, size_pick);
			case ($urandom_range(0, 3))
				0: write_reg(rrs_pkg::REG_RING_LG, $urandom_range(0, 31));
				1: write_reg(rrs_pkg::REG_RING_LG, $urandom_range(0, 8));
				default: write_reg(rrs_pkg::REG_RING_LG, $urandom_range(12, 24));
			endcase
			write_reg(rrs_pkg::REG_LOOP_ENABLE, $urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: write_reg(rrs_pkg::REG_CARD_BYTES, 32'd0);
				4, 5, 6: write_reg(rrs_pkg::REG_CARD_BYTES,
					off_pick + size_pick + $urandom_range(0, 8192));
				7: write_reg(rrs_pkg::REG_CARD_BYTES, 32'hFFFF_FFFF);
				default: write_reg(rrs_pkg::REG_CARD_BYTES, $urandom);
			endcase
			settings_count++;
			// Most phases start a fresh stream; the rest carry the old one on.
			if ($urandom_range(0, 5) != 0)
				send_request(MODE_RESTART, $urandom, 5'($urandom_range(0, 31)), 1'b0,
					rrs_pkg::ST_RUN);
			steps_left = $urandom_range(4, 16);
			while (steps_left > 0 && rand_items < 230) begin
				if (rand_items == 120)
					hold_req = 1'b1;
				no_idle = (rand_items >= 160 && rand_items < 220);
				ring_now = 64'd1 << ((ring_lg_reg > rrs_pkg::RING_LG_MAX)
					? rrs_pkg::RING_LG_MAX : ring_lg_reg);
				mode_pick = MODE_STEP;
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
						play_pick = fill_mark - $urandom_range(0, 32'(ring_now));
					14, 15: play_pick = fill_mark - 32'(ring_now);
					16: play_pick = fill_mark - 32'(ring_now) - 32'd1;
					17: begin
						mode_pick = MODE_RESTART;
						play_pick = $urandom;
					end
					default: play_pick = $urandom;
				endcase
				case ($urandom_range(0, 19))
					0, 1: budget_pick = 5'd0;
					2, 3, 4, 5: budget_pick = 5'($urandom_range(17, 31));
					default: budget_pick = 5'($urandom_range(1, 16));
				endcase
				send_request(mode_pick, play_pick, budget_pick, 1'b0, rrs_pkg::ST_RUN);
				rand_items++;
				steps_left--;
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Ran %0d requests (%0d restarts) under %0d random register settings.",
			request_count, restart_count, settings_count);
		$display("Checked %0d commands, %0d of them copies moving %0d bytes in all.",
			cmd_count, copy_count, bytes_planned);
		if (err_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
